// ----- design/pce_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pce_pkg: shared types and constants of the phase change energy block
// Phase format, CORDIC datapath widths, arctangent table and the cell bus.
// ----------------------------------------------------------------------------
package pce_pkg;

  // Scaled CORDIC datapath: samples are brought to a magnitude of 2^39,
  // negated and grown by the CORDIC gain, which stays below 2^42.
  localparam int SCALED_W     = 40;
  localparam int CW           = 43;
  // Angle accumulator, phase, squared difference and frame sum.
  localparam int ZW           = 17;
  localparam int PH_W         = 16;
  localparam int SQ_W         = 34;
  localparam int SUM_W        = 44;
  localparam int CORDIC_STEPS = 14;

  localparam logic [6:0] SIDE_RESET = 7'd64;

  localparam logic signed [PH_W-1:0] PI_Q           = 16'sd25736;
  localparam logic signed [PH_W-1:0] NEG_PI_Q       = -16'sd25736;
  localparam logic signed [PH_W-1:0] HALF_PI_Q      = 16'sd12868;
  localparam logic signed [PH_W-1:0] NEG_HALF_PI_Q  = -16'sd12868;

  // One CORDIC vector in flight between neighboring cells.
  typedef struct packed {
    logic                valid;
    logic [CW-1:0]       x;
    logic [CW-1:0]       y;
    logic [ZW-1:0]       z;
  } pce_cell_t;

  // atan(2^-step) in Q2.13, rounded to nearest.
  function automatic logic signed [ZW-1:0] atan_q(input int unsigned step);
    logic signed [ZW-1:0] t;
    unique case (step)
      0:       t = 17'sd6434;
      1:       t = 17'sd3798;
      2:       t = 17'sd2007;
      3:       t = 17'sd1019;
      4:       t = 17'sd511;
      5:       t = 17'sd256;
      6:       t = 17'sd128;
      7:       t = 17'sd64;
      8:       t = 17'sd32;
      9:       t = 17'sd16;
      10:      t = 17'sd8;
      11:      t = 17'sd4;
      12:      t = 17'sd2;
      13:      t = 17'sd1;
      default: t = 17'sd0;
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

// ----- design/pce_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pce_if: stream interfaces of the phase change energy block
// Complex sample channel and frame sum channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pce_cplx_if #(
  parameter int SAMPLE_WIDTH = 16
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] real_part;
  logic signed [SAMPLE_WIDTH-1:0] imag_part;

  modport source (output valid, output real_part, output imag_part, input ready);
  modport sink   (input valid, input real_part, input imag_part, output ready);
endinterface

interface pce_sum_if
  import pce_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [SUM_W-1:0] phase_change_sum;

  modport source (output valid, output phase_change_sum, input ready);
  modport sink   (input valid, input phase_change_sum, output ready);
endinterface
`default_nettype wire

// ----- design/pce_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pce_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- design/pce_cordic_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pce_cordic_cell: one CORDIC vectoring step
// Rotates the vector toward the real axis by atan(2^-STEP) and registers it.
// ----------------------------------------------------------------------------
module pce_cordic_cell
  import pce_pkg::*;
#(
  parameter int STEP = 0
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      adv,
  input  wire pce_cell_t cell_in,
  output pce_cell_t      cell_out
);

  logic                 valid_r;
  logic signed [CW-1:0] x_r, y_r, x_nxt, y_nxt, x_in, y_in, xs, ys;
  logic signed [ZW-1:0] z_r, z_nxt, z_in, t;

  always_comb begin
    x_in = cell_in.x;
    y_in = cell_in.y;
    z_in = cell_in.z;
    xs   = x_in >>> STEP;
    ys   = y_in >>> STEP;
    t    = atan_q(STEP);
    if (!y_in[CW-1]) begin
      x_nxt = x_in + ys;
      y_nxt = y_in - xs;
      z_nxt = z_in + t;
    end else begin
      x_nxt = x_in - ys;
      y_nxt = y_in + xs;
      z_nxt = z_in - t;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= cell_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign cell_out = '{valid: valid_r, x: x_r, y: y_r, z: z_r};

endmodule
`default_nettype wire

// ----- design/phase_change_energy.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// phase_change_energy: frame-to-frame phase change energy of a complex grid
// A frame's last beat passes the pre-stage, CORDIC, phase, difference and square
// registers before its sum is valid. Throughput: one beat per cycle; the pipeline
// stalls only while a finished frame sum waits in the output register and the
// next one is ready to leave. Reset (synchronous, rst_n low) empties the pipeline,
// sets side length 64 and treats the phase store as zero with no clearing pass.
// ----------------------------------------------------------------------------
module phase_change_energy
  import pce_pkg::*;
#(
  parameter int MAX_SIDE     = 64,
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  pce_cplx_if.sink        in_bus,
  pce_sum_if.source       out_bus,
  input  wire logic       cfg_we,
  input  wire logic [6:0] cfg_wdata
);

  // The phase store holds one Q2.13 phase per grid position. Its address
  // width follows from the largest frame.
  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int N_W   = IDX_W + 1;
  localparam int SHIFT = SCALED_W - SAMPLE_WIDTH;

  // Side information that travels next to the CORDIC cells: the exact-axis
  // answer, whether this element belongs to the first frame after reset or a
  // side length write, whether it closes a frame, and its store address.
  typedef struct packed {
    logic              direct;
    logic [PH_W-1:0]   dval;
    logic              fresh;
    logic              last;
    logic [IDX_W-1:0]  addr;
  } sb_t;

  // ---------------------------------------------------------------------------
  // Global pipeline advance. Everything moves together; the only hold-up is a
  // frame sum arriving at the output register while the previous one has not
  // been taken yet.
  // ---------------------------------------------------------------------------
  logic adv;
  logic q_valid_r, q_last_r;
  logic out_valid_r;

  assign adv = !(q_valid_r && q_last_r && out_valid_r && !out_bus.ready);
  assign in_bus.ready = adv;

  logic accept;
  assign accept = in_bus.valid && adv;

  // ---------------------------------------------------------------------------
  // Frame bookkeeping at the input side. The frame size is the clamped side
  // length squared; the element index walks the frame in raster order.
  // ---------------------------------------------------------------------------
  logic [6:0]       side_r;
  logic [IDX_W-1:0] idx_r;
  logic             fresh_r;
  logic [8:0]       side9, side_c;
  logic [17:0]      side18, n_full;
  logic [N_W-1:0]   n_elems, idx_inc;
  logic             in_last;

  always_comb begin
    side9 = {2'b00, side_r};
    if (side9 == 9'd0) begin
      side_c = 9'd1;
    end else if (side9 > 9'(MAX_SIDE)) begin
      side_c = 9'(MAX_SIDE);
    end else begin
      side_c = side9;
    end
    side18  = 18'(side_c);
    n_full  = side18 * side18;
    n_elems = N_W'(n_full);
    idx_inc = {1'b0, idx_r} + N_W'(1);
    in_last = (idx_inc >= n_elems);
  end

  // Writing the side length starts a new frame and makes every stored phase
  // read as zero again. Until a whole frame has gone by, the store is only
  // read at positions this frame has not written yet, so the fresh flag is
  // enough to stand in for a cleared memory.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r  <= SIDE_RESET;
      idx_r   <= '0;
      fresh_r <= 1'b1;
    end else if (cfg_we) begin
      side_r  <= cfg_wdata;
      idx_r   <= '0;
      fresh_r <= 1'b1;
    end else if (accept) begin
      idx_r <= in_last ? '0 : idx_inc[IDX_W-1:0];
      if (in_last) begin
        fresh_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Pre-stage: sign extension, scaling to a magnitude of 2^39, the exact-axis
  // answers, and the fold of the left half plane onto the right half.
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0]   re_sc, im_sc, x0, y0;
  logic signed [ZW-1:0]   z0;
  logic                   re_neg, re_zero, im_neg, im_zero;
  logic                   direct0;
  logic signed [PH_W-1:0] dval0;

  always_comb begin
    re_sc   = CW'(in_bus.real_part) <<< SHIFT;
    im_sc   = CW'(in_bus.imag_part) <<< SHIFT;
    re_neg  = in_bus.real_part[SAMPLE_WIDTH-1];
    im_neg  = in_bus.imag_part[SAMPLE_WIDTH-1];
    re_zero = (in_bus.real_part == '0);
    im_zero = (in_bus.imag_part == '0);

    direct0 = im_zero || re_zero;
    if (im_zero) begin
      dval0 = re_neg ? PI_Q : '0;
    end else begin
      dval0 = im_neg ? NEG_HALF_PI_Q : HALF_PI_Q;
    end

    if (re_neg) begin
      x0 = -re_sc;
      y0 = -im_sc;
      z0 = im_neg ? ZW'(NEG_PI_Q) : ZW'(PI_Q);
    end else begin
      x0 = re_sc;
      y0 = im_sc;
      z0 = '0;
    end
  end

  logic                 pre_valid_r;
  logic signed [CW-1:0] pre_x_r, pre_y_r;
  logic signed [ZW-1:0] pre_z_r;
  sb_t                  sb_r [CORDIC_STEPS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_valid_r <= 1'b0;
    end else if (adv) begin
      pre_valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pre_x_r  <= x0;
      pre_y_r  <= y0;
      pre_z_r  <= z0;
      sb_r[0]  <= '{direct: direct0, dval: dval0, fresh: fresh_r, last: in_last,
                    addr: idx_r};
      for (int k = 0; k < CORDIC_STEPS; k++) begin
        sb_r[k+1] <= sb_r[k];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Row of CORDIC cells, one vectoring step each.
  // ---------------------------------------------------------------------------
  pce_cell_t chain [CORDIC_STEPS+1];

  assign chain[0] = '{valid: pre_valid_r, x: pre_x_r, y: pre_y_r, z: pre_z_r};

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
    pce_cordic_cell #(
      .STEP (k)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .cell_in  (chain[k]),
      .cell_out (chain[k+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Phase stage: clamp the angle, pick the exact-axis answer where there is
  // one, and read the previous frame's phase at the same position.
  // ---------------------------------------------------------------------------
  logic signed [ZW-1:0]   z_fin;
  logic signed [PH_W-1:0] phase;
  sb_t                    sb_end;

  assign sb_end = sb_r[CORDIC_STEPS];

  always_comb begin
    z_fin = chain[CORDIC_STEPS].z;
    if (sb_end.direct) begin
      phase = sb_end.dval;
    end else if (z_fin > ZW'(PI_Q)) begin
      phase = PI_Q;
    end else if (z_fin < ZW'(NEG_PI_Q)) begin
      phase = NEG_PI_Q;
    end else begin
      phase = z_fin[PH_W-1:0];
    end
  end

  logic                   p_valid_r, p_last_r, p_fresh_r, p_byp_r;
  logic signed [PH_W-1:0] p_phase_r, p_bypd_r;
  logic [IDX_W-1:0]       p_addr_r;
  logic [PH_W-1:0]        ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else if (adv) begin
      p_valid_r <= chain[CORDIC_STEPS].valid;
    end
  end

  // The element ahead writes its phase in the same cycle this one reads the
  // store; when both address the same position (a one-element frame) the
  // write data is forwarded instead of the stale memory word.
  always_ff @(posedge clk) begin
    if (adv) begin
      p_phase_r <= phase;
      p_addr_r  <= sb_end.addr;
      p_last_r  <= sb_end.last;
      p_fresh_r <= sb_end.fresh;
      p_byp_r   <= p_valid_r && (p_addr_r == sb_end.addr);
      p_bypd_r  <= p_phase_r;
    end
  end

  pce_ram #(
    .WIDTH (PH_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (adv && p_valid_r),
    .waddr (p_addr_r),
    .wdata (p_phase_r),
    .re    (adv),
    .raddr (sb_end.addr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Difference stage: new phase minus previous phase, not wrapped.
  // ---------------------------------------------------------------------------
  logic signed [PH_W-1:0] prev;
  logic signed [ZW-1:0]   diff;
  logic                   d_valid_r, d_last_r;
  logic signed [ZW-1:0]   d_r;

  always_comb begin
    if (p_fresh_r) begin
      prev = '0;
    end else if (p_byp_r) begin
      prev = p_bypd_r;
    end else begin
      prev = $signed(ram_rdata);
    end
    diff = ZW'(p_phase_r) - ZW'(prev);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r <= 1'b0;
    end else if (adv) begin
      d_valid_r <= p_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_r      <= diff;
      d_last_r <= p_last_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Square stage.
  // ---------------------------------------------------------------------------
  logic signed [SQ_W-1:0] d_ext, sq_full;
  logic [SQ_W-1:0]        q_r;

  always_comb begin
    d_ext   = SQ_W'(d_r);
    sq_full = d_ext * d_ext;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_valid_r <= 1'b0;
    end else if (adv) begin
      q_valid_r <= d_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q_r      <= sq_full;
      q_last_r <= d_last_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Saturating accumulator and output register. The last element of a frame
  // moves the sum into the output register and clears the accumulator.
  // ---------------------------------------------------------------------------
  logic [SUM_W-1:0] acc_r, out_sum_r, acc_sat;
  logic [SUM_W:0]   acc_sum;

  always_comb begin
    acc_sum = {1'b0, acc_r} + (SUM_W+1)'(q_r);
    acc_sat = acc_sum[SUM_W] ? '1 : acc_sum[SUM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        acc_r <= '0;
      end else if (adv && q_valid_r) begin
        acc_r <= q_last_r ? '0 : acc_sat;
      end
      if (adv && q_valid_r && q_last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && q_valid_r && q_last_r) begin
      out_sum_r <= acc_sat;
    end
  end

  assign out_bus.valid            = out_valid_r;
  assign out_bus.phase_change_sum = out_sum_r;

endmodule
`default_nettype wire

// ----- dv/phase_change_energy_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// phase_change_energy_checker: frame energy scoreboard
// Watches the sample, sum and configuration ports, keeps its own phase grid
// and frame energy, and compares every sum beat with the oldest prediction.
// ----------------------------------------------------------------------------
module phase_change_energy_checker
  import pce_pkg::*;
#(
  parameter int MAX_SIDE     = 64,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] in_real,
  input  logic signed [SAMPLE_WIDTH-1:0] in_imag,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [SUM_W-1:0]               out_sum,
  input  logic                           cfg_we,
  input  logic [6:0]                     cfg_wdata,
  output int unsigned                    err_count,
  output int unsigned                    pending
);

  localparam int GRID_DEPTH = MAX_SIDE * MAX_SIDE;
  localparam logic [SUM_W-1:0] ENERGY_MAX = '1;
  localparam int ATAN_Q213 [CORDIC_STEPS] = '{
    6434, 3798, 2007, 1019, 511, 256, 128, 64, 32, 16, 8, 4, 2, 1
  };

  logic [6:0]              side_reg;
  logic signed [PH_W-1:0]  last_phase [GRID_DEPTH];
  int unsigned             grid_pos;
  logic [SUM_W-1:0]        frame_energy;
  logic [SUM_W-1:0]        expected_energy [$];

  function automatic int unsigned grid_elements(input logic [6:0] side);
    int unsigned s;
    s = side;
    if (s == 0) s = 1;
    if (s > MAX_SIDE) s = MAX_SIDE;
    return s * s;
  endfunction

  // Vectoring CORDIC on samples scaled up to the 40-bit datapath magnitude.
  function automatic logic signed [PH_W-1:0] cordic_angle(
    input logic signed [SAMPLE_WIDTH-1:0] re,
    input logic signed [SAMPLE_WIDTH-1:0] im
  );
    longint x;
    longint y;
    longint xs;
    longint ys;
    int     z;
    if (im == 0) return (re < 0) ? PI_Q : '0;
    if (re == 0) return (im > 0) ? HALF_PI_Q : NEG_HALF_PI_Q;
    x = longint'(re) <<< (SCALED_W - SAMPLE_WIDTH);
    y = longint'(im) <<< (SCALED_W - SAMPLE_WIDTH);
    z = 0;
    if (x < 0) begin
      z = (y >= 0) ? int'(PI_Q) : int'(NEG_PI_Q);
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_Q213[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_Q213[i];
      end
    end
    if (z > int'(PI_Q)) z = int'(PI_Q);
    if (z < int'(NEG_PI_Q)) z = int'(NEG_PI_Q);
    return z[PH_W-1:0];
  endfunction

  always @(posedge clk) begin : scoreboard
    logic signed [PH_W-1:0] new_phase;
    longint                 diff;
    logic [SUM_W:0]         total;
    logic [SUM_W-1:0]       want;
    int unsigned            pos;
    int unsigned            n;
    if (!rst_n) begin
      side_reg     = SIDE_RESET;
      foreach (last_phase[i]) last_phase[i] = '0;
      grid_pos     = 0;
      frame_energy = '0;
      expected_energy.delete();
      err_count   <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_energy.size() == 0) begin
          $display("%0t: unexpected frame sum %0d", $time, out_sum);
          err_count <= err_count + 1;
        end else begin
          want = expected_energy.pop_front();
          if (out_sum !== want) begin
            $display("%0t: frame sum mismatch, expected %0d, actual %0d",
                     $time, want, out_sum);
            err_count <= err_count + 1;
          end
        end
      end
      // A side length write restarts the frame and forgets the old phases.
      if (cfg_we) begin
        side_reg     = cfg_wdata;
        foreach (last_phase[i]) last_phase[i] = '0;
        grid_pos     = 0;
        frame_energy = '0;
      end
      if (in_valid && in_ready) begin
        n   = grid_elements(side_reg);
        pos = (grid_pos >= n) ? 0 : grid_pos;
        new_phase = cordic_angle(in_real, in_imag);
        diff  = longint'(new_phase) - longint'(last_phase[pos]);
        total = {1'b0, frame_energy} + (SUM_W+1)'(diff * diff);
        frame_energy = (total > {1'b0, ENERGY_MAX}) ? ENERGY_MAX : total[SUM_W-1:0];
        last_phase[pos] = new_phase;
        if (pos + 1 >= n) begin
          expected_energy.push_back(frame_energy);
          frame_energy = '0;
          grid_pos     = 0;
        end else begin
          grid_pos = pos + 1;
        end
      end
    end
    pending <= expected_energy.size();
  end

endmodule

// ----- dv/phase_change_energy_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// phase_change_energy_tb: stimulus and verdict for the phase change energy block
// Streams frames of complex samples under several side lengths and handshake
// pacings, while a separate checker predicts and compares every frame sum.
// ----------------------------------------------------------------------------
module phase_change_energy_tb;
  import pce_pkg::*;

  localparam int MAX_SIDE     = 64;
  localparam int SAMPLE_WIDTH = 16;
  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 11;
  // A frame's last beat passes the whole pipeline before its sum appears; the
  // margin covers beats still in the pipeline that end no frame.
  localparam int DRAIN_CYCLES = 30;
  // Long enough for the pipeline behind a held sum to fill and stall input.
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 600000;

  // Handshake pacing: who idles and how often.
  typedef enum logic [1:0] {
    PACE_SLOW_SINK,    // sender idles 20 percent of the time, receiver 80
    PACE_SLOW_SOURCE,  // sender idles 80 percent of the time, receiver 20
    PACE_FULL          // neither side idles
  } pace_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] re;
    logic signed [SAMPLE_WIDTH-1:0] im;
  } sample_t;

  // Corner samples: origin, all four axis directions, the component extremes,
  // unit diagonals in every quadrant, and points just above and below the
  // negative real axis, where the phase jumps from +pi to -pi unwrapped.
  localparam sample_t CORNER_SAMPLES [0:21] = '{
    '{16'sd0,      16'sd0},
    '{16'sd100,    16'sd0},
    '{-16'sd100,   16'sd0},
    '{16'sd0,      16'sd100},
    '{16'sd0,      -16'sd100},
    '{16'sh8000,   16'sd0},
    '{16'sh7FFF,   16'sd0},
    '{16'sd0,      16'sh8000},
    '{16'sd0,      16'sh7FFF},
    '{16'sh7FFF,   16'sh7FFF},
    '{16'sh8000,   16'sh8000},
    '{16'sh8000,   16'sh7FFF},
    '{16'sh7FFF,   16'sh8000},
    '{-16'sd1,     16'sd1},
    '{-16'sd1,     -16'sd1},
    '{16'sd1,      -16'sd1},
    '{16'sd1,      16'sd1},
    '{16'sh8000,   16'sd1},
    '{16'sh8000,   -16'sd1},
    '{-16'sd1,     16'sd0},
    '{16'sd12345,  -16'sd23456},
    '{-16'sd20000, 16'sd7}
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [6:0]  cfg_wdata;
  pace_t       pace = PACE_SLOW_SINK;
  int          side_now;
  int unsigned stall_requests = 0;
  int unsigned stalls_served = 0;
  int unsigned err_count;
  int unsigned pending;
  int unsigned cycle_count = 0;

  pce_cplx_if #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) sample_if ();
  pce_sum_if                                 energy_if ();

  phase_change_energy #(
    .MAX_SIDE     (MAX_SIDE),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (sample_if),
    .out_bus   (energy_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  phase_change_energy_checker #(
    .MAX_SIDE     (MAX_SIDE),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample_if.valid),
    .in_ready  (sample_if.ready),
    .in_real   (sample_if.real_part),
    .in_imag   (sample_if.imag_part),
    .out_valid (energy_if.valid),
    .out_ready (energy_if.ready),
    .out_sum   (energy_if.phase_change_sum),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .err_count (err_count),
    .pending   (pending)
  );

  always #(CLK_HALF) clk = ~clk;

  // Watchdog: a hung handshake or a lost frame sum ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic bit idle_roll(input int pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  // Random component: mostly full range, with a fair share of zero, the two
  // extremes and tiny values so that the axis shortcuts come up often.
  function automatic logic signed [SAMPLE_WIDTH-1:0] random_component();
    int small_val;
    small_val = int'($urandom_range(8, 0)) - 4;
    case ($urandom_range(9, 0))
      0:       return '0;
      1:       return {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
      2:       return {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
      3:       return small_val[SAMPLE_WIDTH-1:0];
      default: return SAMPLE_WIDTH'($urandom);
    endcase
  endfunction

  function automatic int frame_len(input int side);
    int s;
    s = (side == 0) ? 1 : (side > MAX_SIDE) ? MAX_SIDE : side;
    return s * s;
  endfunction

  // The receiver changes ready at the falling edge. A stall request makes it
  // hold off for a long stretch, counted here, while the sender keeps going.
  initial begin
    energy_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stalls_served != stall_requests) begin
        energy_if.ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        stalls_served++;
      end else begin
        case (pace)
          PACE_SLOW_SINK:   energy_if.ready = !idle_roll(80);
          PACE_SLOW_SOURCE: energy_if.ready = !idle_roll(20);
          default:          energy_if.ready = 1'b1;
        endcase
      end
    end
  end

  // Offers one beat, starting and ending at a falling edge. On return valid
  // is still high; the caller either offers the next beat right away or
  // lowers valid at the same edge.
  task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] re,
                             input logic signed [SAMPLE_WIDTH-1:0] im);
    int idle_pct;
    idle_pct = (pace == PACE_SLOW_SINK) ? 20 : (pace == PACE_SLOW_SOURCE) ? 80 : 0;
    while (idle_roll(idle_pct)) begin
      sample_if.valid = 1'b0;
      @(negedge clk);
    end
    sample_if.valid     = 1'b1;
    sample_if.real_part = re;
    sample_if.imag_part = im;
    do @(posedge clk); while (!sample_if.ready);
    @(negedge clk);
  endtask

  // Returns at a falling edge once every predicted frame sum has come out.
  task automatic wait_drain();
    while (pending != 0) @(negedge clk);
  endtask

  // Side length writes happen only with the block empty; the extra cycles
  // flush beats of an unfinished frame that produce no sum.
  task automatic write_side(input logic [6:0] side);
    wait_drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = side;
    @(negedge clk);
    cfg_we    = 1'b0;
    side_now  = side;
  endtask

  // Whole frames of random samples, then a partial frame that the next side
  // length write cuts short. Halfway through, the sender waits until every
  // sum has left; a quarter of the way in, the receiver may be told to stall.
  task automatic run_frames(input int frames, input pace_t p, input bit with_hold);
    int n;
    int tail;
    n    = frame_len(side_now);
    pace = p;
    for (int f = 0; f < frames; f++) begin
      if (with_hold && f == frames / 4) stall_requests++;
      if (f == frames / 2 && f > 0) begin
        sample_if.valid = 1'b0;
        wait_drain();
      end
      for (int e = 0; e < n; e++) send_sample(random_component(), random_component());
    end
    tail = $urandom_range(n - 1, 0);
    for (int e = 0; e < tail; e++) send_sample(random_component(), random_component());
    sample_if.valid = 1'b0;
  endtask

  initial begin
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    sample_if.valid     = 1'b0;
    sample_if.real_part = '0;
    sample_if.imag_part = '0;
    side_now            = SIDE_RESET;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    // First frame against the zeroed phase grid, five by five: the corner
    // samples lead, random samples fill the rest of the frame.
    write_side(7'd5);
    pace = PACE_SLOW_SINK;
    foreach (CORNER_SAMPLES[i]) send_sample(CORNER_SAMPLES[i].re, CORNER_SAMPLES[i].im);
    for (int e = $size(CORNER_SAMPLES); e < frame_len(side_now); e++) begin
      send_sample(random_component(), random_component());
    end
    sample_if.valid = 1'b0;

    // Single-element frames give a sum per beat, so a held receiver backs
    // the pipeline up into the input. A zero side behaves as a side of one.
    write_side(7'd1);
    run_frames(100, PACE_SLOW_SINK, 1'b1);
    write_side(7'd0);
    run_frames(100, PACE_SLOW_SINK, 1'b1);
    write_side(7'd2);
    run_frames(40, PACE_SLOW_SINK, 1'b0);
    write_side(7'd3);
    run_frames(25, PACE_SLOW_SOURCE, 1'b0);
    write_side(7'd5);
    run_frames(15, PACE_SLOW_SOURCE, 1'b0);
    write_side(7'd8);
    run_frames(6, PACE_FULL, 1'b0);
    write_side(7'd13);
    run_frames(1, PACE_FULL, 1'b0);
    write_side(7'd1);
    run_frames(100, PACE_FULL, 1'b1);

    wait_drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
